@@ rtl/core/bdq_pkg.sv @@
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and constants for the bounded deque with search: operation
// codes, status codes and the field widths of the request and result streams.
// ----------------------------------------------------------------------------
package bdq_pkg;

    // field widths
    localparam int FUNC_W    = 3;
    localparam int VALUE_W   = 32;
    localparam int POS_W     = 4;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 5;
    localparam int RES_W     = VALUE_W + POS_W + 1 + STATUS_W + COUNT_W;
    localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;
    localparam int PAD_W     = M_TDATA_W - RES_W;

    // operation selected by a request
    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_BACK  = 3'd0,
        FN_PUSH_FRONT = 3'd1,
        FN_POP_FRONT  = 3'd2,
        FN_POP_BACK   = 3'd3,
        FN_SEARCH     = 3'd4,
        FN_EVEN_FRONT = 3'd5,
        FN_EVEN_BACK  = 3'd6,
        FN_ORDERED    = 3'd7
    } func_t;

    // result status
    typedef enum logic [STATUS_W-1:0] {
        STS_OK    = 2'd0,
        STS_EMPTY = 2'd1,
        STS_FULL  = 2'd2
    } status_t;

endpackage

@@ rtl/core/bounded_deque_with_search.sv @@
// States per request: a push, or any request on an empty queue, goes IDLE, START,
// DONE; a pop adds POP after START; search / even / order check walk entries in SCAN.
// Throughput: one request at a time; the ring memory's single read port walks
// one entry per cycle, so a scan reads every live entry when nothing hits.
// Reset (aresetn low, synchronous): queue empty, head at slot 0, no result
// pending. Ring contents are not cleared and are only read once written.
// ----------------------------------------------------------------------------
// bounded_deque_with_search
// Double-ended queue of signed 32-bit values held in a ring memory with a
// head pointer and a count, with a sequencer that scans entries one per cycle.
// ----------------------------------------------------------------------------
module bounded_deque_with_search #(
    parameter int DEPTH = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // request stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [bdq_pkg::VALUE_W-1:0]    s_axis_tdata,   // [31:0] value
    input  logic [bdq_pkg::FUNC_W-1:0]     s_axis_tuser,   // [2:0] func
    // result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [31:0] data, [35:32] position, [36] found, [38:37] status,
    // [43:39] count, [47:44] zero
    output logic [bdq_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_POP,
        ST_DONE
    } state_t;

    state_t                           state_reg;
    bdq_pkg::func_t                   func_reg;
    logic [bdq_pkg::VALUE_W-1:0]      value_reg;
    logic [PW-1:0]                    head_reg;
    logic [CW-1:0]                    count_reg;
    logic [PW-1:0]                    ptr_reg;
    logic [PW-1:0]                    idx_reg;
    logic [PW-1:0]                    rd_idx_reg;
    logic                             rd_vld_reg;
    logic [CW-1:0]                    iss_left_reg;
    logic [CW-1:0]                    chk_left_reg;
    logic                             first_reg;
    logic [bdq_pkg::VALUE_W-1:0]      prev_reg;
    logic [bdq_pkg::VALUE_W-1:0]      rdata_reg;
    logic [bdq_pkg::VALUE_W-1:0]      res_data_reg;
    logic [bdq_pkg::POS_W-1:0]        res_pos_reg;
    logic                             res_found_reg;
    bdq_pkg::status_t                 res_status_reg;
    logic                             m_tvalid_reg;
    logic [bdq_pkg::M_TDATA_W-1:0]    m_tdata_reg;

    logic [bdq_pkg::VALUE_W-1:0]      mem [DEPTH];

    function automatic logic [PW-1:0] ring_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PW-1:0] ring_dec(input logic [PW-1:0] p);
        return (p == '0) ? PW'(DEPTH - 1) : p - 1'b1;
    endfunction

    // decoded request
    logic is_push, is_pop, is_back, full, empty;
    assign is_push = (func_reg == bdq_pkg::FN_PUSH_BACK) || (func_reg == bdq_pkg::FN_PUSH_FRONT);
    assign is_pop  = (func_reg == bdq_pkg::FN_POP_FRONT) || (func_reg == bdq_pkg::FN_POP_BACK);
    assign is_back = (func_reg == bdq_pkg::FN_POP_BACK) || (func_reg == bdq_pkg::FN_EVEN_BACK);
    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);

    // ring slot of the tail (push back) or of the last entry (back reads)
    logic [PW:0]   addr_sum;
    logic [PW-1:0] ring_addr;
    always_comb begin
        addr_sum = {1'b0, head_reg} + (PW+1)'(count_reg) - (PW+1)'(is_back);
        if (addr_sum >= (PW+1)'(DEPTH)) begin
            ring_addr = PW'(addr_sum - (PW+1)'(DEPTH));
        end else begin
            ring_addr = PW'(addr_sum);
        end
    end

    // memory port control
    logic                        wr_en, rd_en;
    logic [PW-1:0]               wr_addr, rd_addr;
    logic                        issue;
    assign issue   = (state_reg == ST_SCAN) && (iss_left_reg != '0);
    assign wr_en   = (state_reg == ST_START) && is_push && !full;
    assign wr_addr = (func_reg == bdq_pkg::FN_PUSH_FRONT) ? ring_dec(head_reg) : ring_addr;
    assign rd_en   = issue || ((state_reg == ST_START) && is_pop && !empty);
    assign rd_addr = (state_reg == ST_SCAN) ? ptr_reg :
                     ((func_reg == bdq_pkg::FN_POP_FRONT) ? head_reg : ring_addr);

    // ring memory, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= value_reg;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // shared compare on the entry just read
    logic hit;
    always_comb begin
        unique case (func_reg)
            bdq_pkg::FN_SEARCH:     hit = (rdata_reg == value_reg);
            bdq_pkg::FN_EVEN_FRONT,
            bdq_pkg::FN_EVEN_BACK:  hit = !rdata_reg[0];
            bdq_pkg::FN_ORDERED:    hit = !first_reg && ($signed(prev_reg) < $signed(rdata_reg));
            default:                hit = 1'b0;
        endcase
    end

    logic out_free;
    assign out_free = !m_tvalid_reg || m_axis_tready;

    // sequencer, queue pointers and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            count_reg    <= '0;
            rd_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            rd_vld_reg <= issue;

            // result register: load when done, clear once taken
            if ((state_reg == ST_DONE) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        func_reg  <= bdq_pkg::func_t'(s_axis_tuser);
                        value_reg <= s_axis_tdata;
                        state_reg <= ST_START;
                    end
                end

                ST_START: begin
                    res_data_reg <= '0;
                    res_pos_reg  <= '0;
                    if (is_push) begin
                        // push, or drop when full
                        res_found_reg  <= 1'b0;
                        res_status_reg <= full ? bdq_pkg::STS_FULL : bdq_pkg::STS_OK;
                        if (!full) begin
                            count_reg <= count_reg + 1'b1;
                            if (func_reg == bdq_pkg::FN_PUSH_FRONT) begin
                                head_reg <= ring_dec(head_reg);
                            end
                        end
                        state_reg <= ST_DONE;
                    end else if (empty) begin
                        // empty queue counts as ordered
                        res_status_reg <= bdq_pkg::STS_EMPTY;
                        res_found_reg  <= (func_reg == bdq_pkg::FN_ORDERED);
                        state_reg      <= ST_DONE;
                    end else if (is_pop) begin
                        res_found_reg  <= 1'b0;
                        res_status_reg <= bdq_pkg::STS_OK;
                        state_reg      <= ST_POP;
                    end else begin
                        // set up the walk over the live entries
                        res_found_reg  <= 1'b0;
                        res_status_reg <= bdq_pkg::STS_OK;
                        if (func_reg == bdq_pkg::FN_EVEN_BACK) begin
                            ptr_reg <= ring_addr;
                            idx_reg <= PW'(count_reg - 1'b1);
                        end else begin
                            ptr_reg <= head_reg;
                            idx_reg <= '0;
                        end
                        iss_left_reg <= count_reg;
                        chk_left_reg <= count_reg;
                        first_reg    <= 1'b1;
                        state_reg    <= ST_SCAN;
                    end
                end

                ST_POP: begin
                    res_data_reg <= rdata_reg;
                    count_reg    <= count_reg - 1'b1;
                    if (func_reg == bdq_pkg::FN_POP_FRONT) begin
                        head_reg <= ring_inc(head_reg);
                    end
                    state_reg <= ST_DONE;
                end

                ST_SCAN: begin
                    // read side: one entry per cycle
                    if (issue) begin
                        iss_left_reg <= iss_left_reg - 1'b1;
                        rd_idx_reg   <= idx_reg;
                        if (func_reg == bdq_pkg::FN_EVEN_BACK) begin
                            ptr_reg <= ring_dec(ptr_reg);
                            idx_reg <= idx_reg - 1'b1;
                        end else begin
                            ptr_reg <= ring_inc(ptr_reg);
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                    // check side: in the cycle after the read
                    if (rd_vld_reg) begin
                        prev_reg     <= rdata_reg;
                        first_reg    <= 1'b0;
                        chk_left_reg <= chk_left_reg - 1'b1;
                        if (hit) begin
                            res_found_reg <= (func_reg != bdq_pkg::FN_ORDERED);
                            res_pos_reg   <= (func_reg != bdq_pkg::FN_ORDERED) ?
                                             bdq_pkg::POS_W'(rd_idx_reg) : '0;
                            res_data_reg  <= ((func_reg == bdq_pkg::FN_EVEN_FRONT) ||
                                              (func_reg == bdq_pkg::FN_EVEN_BACK)) ?
                                             rdata_reg : '0;
                            state_reg     <= ST_DONE;
                        end else if (chk_left_reg == CW'(1)) begin
                            res_found_reg <= (func_reg == bdq_pkg::FN_ORDERED);
                            state_reg     <= ST_DONE;
                        end
                    end
                end

                ST_DONE: begin
                    if (out_free) begin
                        m_tdata_reg  <= {bdq_pkg::PAD_W'(0),
                                         bdq_pkg::COUNT_W'(count_reg),
                                         res_status_reg,
                                         res_found_reg,
                                         res_pos_reg,
                                         res_data_reg};
                        state_reg    <= ST_IDLE;
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bounded deque with search. Requests go in on
// the input stream, and a behavioral copy of the deque predicts each result.
// Every result is checked field by field against that prediction, or against
// the typed result of known rows. A table of directed requests comes first, then
// random bursts that fill the deque, drain it, build sorted runs, use odd-only
// pushes and mix in noise. Both streams idle and stall at random throughout the run.
// ----------------------------------------------------------------------------
module testbench;

    localparam int DEPTH         = 16;
    localparam int RANDOM_ITEMS  = 1000;
    localparam int PLAN_ROWS     = 22;
    localparam int STALL_LIMIT   = 2000;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = DEPTH + 8;

    // one result, laid out exactly as on m_axis_tdata (data in the low bits)
    typedef struct packed {
        logic [bdq_pkg::PAD_W-1:0]    pad;
        logic [bdq_pkg::COUNT_W-1:0]  count;
        bdq_pkg::status_t             status;
        logic                         found;
        logic [bdq_pkg::POS_W-1:0]    pos;
        logic [bdq_pkg::VALUE_W-1:0]  data;
    } deque_result_t;

    // one row of the directed table; known rows carry their result typed in
    typedef struct {
        bdq_pkg::func_t               fn;
        logic [bdq_pkg::VALUE_W-1:0]  val;
        int                           reps;
        bit                           known;
        deque_result_t                want;
    } plan_row_t;

    typedef enum int {
        BURST_MIX,
        BURST_FILL,
        BURST_DRAIN,
        BURST_SORTED,
        BURST_ODD
    } burst_t;

    logic                          aclk          = 1'b0;
    logic                          aresetn       = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [bdq_pkg::VALUE_W-1:0]   s_axis_tdata  = '0;   // [31:0] value
    logic [bdq_pkg::FUNC_W-1:0]    s_axis_tuser  = '0;   // [2:0] func
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    // [31:0] data, [35:32] position, [36] found, [38:37] status,
    // [43:39] count, [47:44] zero
    logic [bdq_pkg::M_TDATA_W-1:0] m_axis_tdata;

    // shadow deque
    logic [bdq_pkg::VALUE_W-1:0]   ring [DEPTH];
    logic [bdq_pkg::POS_W-1:0]     front = '0;
    int                            held  = 0;

    deque_result_t        pending_results [$];
    plan_row_t            plan [PLAN_ROWS];

    int                   requests_sent   = 0;
    int                   results_checked = 0;
    int                   failures        = 0;
    int                   dropped_pushes  = 0;
    int                   empty_requests  = 0;
    int                   ordered_hits    = 0;
    bit                   sender_smooth   = 1'b0;

    bounded_deque_with_search #(
        .DEPTH(DEPTH)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic logic [bdq_pkg::POS_W-1:0] ring_slot(int i);
        return front + bdq_pkg::POS_W'(i);
    endfunction

    function automatic deque_result_t outcome(logic [bdq_pkg::VALUE_W-1:0] d,
                                              logic [bdq_pkg::POS_W-1:0] p,
                                              logic f, bdq_pkg::status_t s,
                                              logic [bdq_pkg::COUNT_W-1:0] c);
        deque_result_t r;
        r        = '0;
        r.data   = d;
        r.pos    = p;
        r.found  = f;
        r.status = s;
        r.count  = c;
        return r;
    endfunction

    // apply one request to the shadow deque and return its result
    function automatic deque_result_t apply_request(bdq_pkg::func_t fn,
                                                    logic [bdq_pkg::VALUE_W-1:0] val);
        deque_result_t res;
        int i;
        res = '0;
        if (fn == bdq_pkg::FN_PUSH_BACK || fn == bdq_pkg::FN_PUSH_FRONT) begin
            if (held >= DEPTH) begin
                res.status = bdq_pkg::STS_FULL;
                dropped_pushes++;
            end else if (fn == bdq_pkg::FN_PUSH_BACK) begin
                ring[ring_slot(held)] = val;
                held++;
            end else begin
                front       = front - 1'b1;
                ring[front] = val;
                held++;
            end
        end else if (held == 0) begin
            // empty queue still counts as ordered
            res.status = bdq_pkg::STS_EMPTY;
            res.found  = (fn == bdq_pkg::FN_ORDERED);
            empty_requests++;
        end else begin
            case (fn)
                bdq_pkg::FN_POP_FRONT: begin
                    res.data = ring[front];
                    front    = front + 1'b1;
                    held--;
                end
                bdq_pkg::FN_POP_BACK: begin
                    res.data = ring[ring_slot(held - 1)];
                    held--;
                end
                bdq_pkg::FN_SEARCH: begin
                    for (i = 0; i < held; i++) begin
                        if (ring[ring_slot(i)] == val) begin
                            res.found = 1'b1;
                            res.pos   = bdq_pkg::POS_W'(i);
                            break;
                        end
                    end
                end
                bdq_pkg::FN_EVEN_FRONT: begin
                    for (i = 0; i < held; i++) begin
                        if (!ring[ring_slot(i)][0]) begin
                            res.found = 1'b1;
                            res.pos   = bdq_pkg::POS_W'(i);
                            res.data  = ring[ring_slot(i)];
                            break;
                        end
                    end
                end
                bdq_pkg::FN_EVEN_BACK: begin
                    for (i = held - 1; i >= 0; i--) begin
                        if (!ring[ring_slot(i)][0]) begin
                            res.found = 1'b1;
                            res.pos   = bdq_pkg::POS_W'(i);
                            res.data  = ring[ring_slot(i)];
                            break;
                        end
                    end
                end
                default: begin
                    // non-increasing from front to back, signed compare
                    res.found = 1'b1;
                    for (i = 0; i + 1 < held; i++) begin
                        if ($signed(ring[ring_slot(i)]) < $signed(ring[ring_slot(i + 1)])) begin
                            res.found = 1'b0;
                            break;
                        end
                    end
                    if (res.found)
                        ordered_hits++;
                end
            endcase
        end
        res.count = bdq_pkg::COUNT_W'(held);
        return res;
    endfunction

    // extremes, small values around zero, or anything
    function automatic logic [bdq_pkg::VALUE_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 4))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'h0000_0000;
                    3:       return 32'hFFFF_FFFF;
                    default: return 32'h0000_0001;
                endcase
            end
            1, 2, 3: return 32'($urandom_range(0, 16)) - 32'd8;
            default: return $urandom();
        endcase
    endfunction

    // a value that is held in the deque, when there is one
    function automatic logic [bdq_pkg::VALUE_W-1:0] stored_value();
        if (held == 0)
            return rand_value();
        return ring[ring_slot($urandom_range(0, held - 1))];
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (sender_smooth || r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // offer one request, wait for its handshake, then record its result
    task automatic issue(bdq_pkg::func_t fn, logic [bdq_pkg::VALUE_W-1:0] val,
                         bit known = 1'b0, deque_result_t typed_result = '0);
        deque_result_t predicted;
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= val;
        do @(posedge aclk); while (!s_axis_tready);
        predicted = apply_request(fn, val);
        pending_results.push_back(known ? typed_result : predicted);
        requests_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic check_field(string name, logic [bdq_pkg::VALUE_W-1:0] want,
                               logic [bdq_pkg::VALUE_W-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            failures++;
        end
    endtask

    // result side: check each accepted result, then pick the next ready
    int stall_left   = 0;
    int phase_cycles = 0;
    int hold_mark    = 300;
    bit calm         = 1'b0;

    always @(posedge aclk) begin
        deque_result_t got;
        deque_result_t want;
        int r;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (pending_results.size() == 0) begin
                $error("result arrived with no request pending");
                failures++;
            end else begin
                want = pending_results.pop_front();
                check_field("data",     want.data, got.data);
                check_field("position", bdq_pkg::VALUE_W'(want.pos),
                            bdq_pkg::VALUE_W'(got.pos));
                check_field("found",    bdq_pkg::VALUE_W'(want.found),
                            bdq_pkg::VALUE_W'(got.found));
                check_field("status",   bdq_pkg::VALUE_W'(want.status),
                            bdq_pkg::VALUE_W'(got.status));
                check_field("count",    bdq_pkg::VALUE_W'(want.count),
                            bdq_pkg::VALUE_W'(got.count));
                check_field("pad",      bdq_pkg::VALUE_W'(want.pad),
                            bdq_pkg::VALUE_W'(got.pad));
                results_checked++;
            end
        end

        // switch at random between stall-free and stalling stretches
        phase_cycles++;
        if (phase_cycles >= 250) begin
            phase_cycles = 0;
            calm         = ($urandom_range(0, 2) == 0);
        end

        // long hold-off so the deque backs up and stalls its input
        if (requests_sent >= hold_mark) begin
            stall_left = LONG_HOLD;
            hold_mark  = (hold_mark < 700) ? 700 : 32'h7FFF_FFFF;
        end else if (stall_left == 0 && !calm) begin
            r = $urandom_range(0, 99);
            if (r < 12)
                stall_left = $urandom_range(1, 3);
            else if (r < 14)
                stall_left = $urandom_range(10, 40);
        end
        m_axis_tready <= (stall_left == 0);
        if (stall_left > 0)
            stall_left--;
    end

    // watchdog on cycles without any handshake
    initial begin : watchdog
        int idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle = 0;
            else
                idle++;
        end
        $display("testbench failed");
        $finish;
    end

    // stimulus
    initial begin : stimulus
        int                                 row;
        int                                 n;
        int                                 goal;
        burst_t                             mode;
        bdq_pkg::func_t                     fn;
        logic signed [bdq_pkg::VALUE_W-1:0] hi;
        logic signed [bdq_pkg::VALUE_W-1:0] lo;

        // empty queue, extremes, signed evenness, then fill past full
        plan = '{
            '{bdq_pkg::FN_POP_FRONT,  32'h1234_5678,  1, 1'b1,
              outcome(0, 0, 0, bdq_pkg::STS_EMPTY, 0)},
            '{bdq_pkg::FN_POP_BACK,   32'hFFFF_FFFF,  1, 1'b1,
              outcome(0, 0, 0, bdq_pkg::STS_EMPTY, 0)},
            '{bdq_pkg::FN_SEARCH,     32'h0000_0000,  1, 1'b1,
              outcome(0, 0, 0, bdq_pkg::STS_EMPTY, 0)},
            '{bdq_pkg::FN_EVEN_FRONT, 32'h0000_0000,  1, 1'b1,
              outcome(0, 0, 0, bdq_pkg::STS_EMPTY, 0)},
            '{bdq_pkg::FN_EVEN_BACK,  32'h0000_0000,  1, 1'b1,
              outcome(0, 0, 0, bdq_pkg::STS_EMPTY, 0)},
            '{bdq_pkg::FN_ORDERED,    32'h8000_0000,  1, 1'b1,
              outcome(0, 0, 1, bdq_pkg::STS_EMPTY, 0)},
            '{bdq_pkg::FN_PUSH_BACK,  32'h7FFF_FFFF,  1, 1'b1,
              outcome(0, 0, 0, bdq_pkg::STS_OK, 1)},
            '{bdq_pkg::FN_PUSH_FRONT, 32'h8000_0000,  1, 1'b0, '0},
            '{bdq_pkg::FN_PUSH_BACK,  32'hFFFF_FFFE,  1, 1'b0, '0},
            '{bdq_pkg::FN_SEARCH,     32'hFFFF_FFFE,  1, 1'b0, '0},
            '{bdq_pkg::FN_SEARCH,     32'h0000_0000,  1, 1'b0, '0},
            '{bdq_pkg::FN_EVEN_FRONT, 32'h0000_0000,  1, 1'b0, '0},
            '{bdq_pkg::FN_EVEN_BACK,  32'h0000_0000,  1, 1'b0, '0},
            '{bdq_pkg::FN_ORDERED,    32'h0000_0000,  1, 1'b0, '0},
            '{bdq_pkg::FN_POP_FRONT,  32'h0000_0000,  1, 1'b0, '0},
            '{bdq_pkg::FN_POP_BACK,   32'h0000_0000,  1, 1'b0, '0},
            '{bdq_pkg::FN_ORDERED,    32'h0000_0000,  1, 1'b0, '0},
            '{bdq_pkg::FN_PUSH_FRONT, 32'h0000_0003, 15, 1'b0, '0},
            '{bdq_pkg::FN_PUSH_BACK,  32'h0000_0004,  1, 1'b1,
              outcome(0, 0, 0, bdq_pkg::STS_FULL, 16)},
            '{bdq_pkg::FN_PUSH_FRONT, 32'h0000_0005,  1, 1'b1,
              outcome(0, 0, 0, bdq_pkg::STS_FULL, 16)},
            '{bdq_pkg::FN_EVEN_BACK,  32'h0000_0000,  1, 1'b0, '0},
            '{bdq_pkg::FN_SEARCH,     32'h7FFF_FFFF,  1, 1'b0, '0}
        };

        // reset
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        for (row = 0; row < PLAN_ROWS; row++) begin
            repeat (plan[row].reps)
                issue(plan[row].fn, plan[row].val, plan[row].known, plan[row].want);
        end

        // random bursts
        goal = requests_sent + RANDOM_ITEMS;
        while (requests_sent < goal) begin
            sender_smooth = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 7))
                3:       mode = BURST_FILL;
                4:       mode = BURST_DRAIN;
                5:       mode = BURST_SORTED;
                6:       mode = BURST_ODD;
                default: mode = BURST_MIX;
            endcase

            case (mode)
                // noise: any request, searches often for a held value
                BURST_MIX: begin
                    n = $urandom_range(6, 20);
                    repeat (n) begin
                        fn = bdq_pkg::func_t'($urandom_range(0, 7));
                        issue(fn, (fn == bdq_pkg::FN_SEARCH && $urandom_range(0, 1)) ?
                                  stored_value() : rand_value());
                    end
                end
                // fill to full, a dropped push or two, then scans over a full ring
                BURST_FILL: begin
                    while (held < DEPTH)
                        issue($urandom_range(0, 1) ? bdq_pkg::FN_PUSH_BACK :
                                                     bdq_pkg::FN_PUSH_FRONT,
                              rand_value());
                    repeat ($urandom_range(1, 2))
                        issue($urandom_range(0, 1) ? bdq_pkg::FN_PUSH_BACK :
                                                     bdq_pkg::FN_PUSH_FRONT,
                              rand_value());
                    issue(bdq_pkg::FN_SEARCH, stored_value());
                    issue(bdq_pkg::FN_EVEN_FRONT, rand_value());
                    issue(bdq_pkg::FN_EVEN_BACK, rand_value());
                    issue(bdq_pkg::FN_ORDERED, rand_value());
                end
                // drain from both ends, then read past empty
                BURST_DRAIN: begin
                    while (held > 0)
                        issue($urandom_range(0, 1) ? bdq_pkg::FN_POP_FRONT :
                                                     bdq_pkg::FN_POP_BACK,
                              rand_value());
                    repeat ($urandom_range(1, 2))
                        issue($urandom_range(0, 1) ? bdq_pkg::FN_POP_FRONT :
                                                     bdq_pkg::FN_POP_BACK,
                              rand_value());
                    issue(bdq_pkg::func_t'($urandom_range(4, 7)), rand_value());
                end
                // non-increasing run built from both ends with an occasional random value, order checks along the way
                BURST_SORTED: begin
                    while (held > 0)
                        issue(bdq_pkg::FN_POP_FRONT, rand_value());
                    hi = rand_value();
                    lo = hi;
                    issue(bdq_pkg::FN_PUSH_BACK, hi);
                    n = $urandom_range(3, 14);
                    repeat (n) begin
                        if ($urandom_range(0, 5) == 0) begin
                            issue(bdq_pkg::FN_PUSH_BACK, rand_value());
                        end else if ($urandom_range(0, 1)) begin
                            lo = lo - $signed(32'($urandom_range(0, 3)));
                            issue(bdq_pkg::FN_PUSH_BACK, lo);
                        end else begin
                            hi = hi + $signed(32'($urandom_range(0, 3)));
                            issue(bdq_pkg::FN_PUSH_FRONT, hi);
                        end
                        if ($urandom_range(0, 2) == 0)
                            issue(bdq_pkg::FN_ORDERED, rand_value());
                    end
                    issue(bdq_pkg::FN_ORDERED, rand_value());
                    issue(bdq_pkg::FN_SEARCH, stored_value());
                end
                // odd values pushed, so even scans hit only on older entries until an even value lands
                default: begin
                    n = $urandom_range(2, 8);
                    repeat (n)
                        issue($urandom_range(0, 1) ? bdq_pkg::FN_PUSH_BACK :
                                                     bdq_pkg::FN_PUSH_FRONT,
                              rand_value() | 32'd1);
                    issue(bdq_pkg::FN_EVEN_FRONT, rand_value());
                    issue(bdq_pkg::FN_EVEN_BACK, rand_value());
                    issue($urandom_range(0, 1) ? bdq_pkg::FN_PUSH_BACK :
                                                 bdq_pkg::FN_PUSH_FRONT,
                          rand_value() & ~32'd1);
                    issue(bdq_pkg::FN_EVEN_BACK, rand_value());
                end
            endcase
        end
        s_axis_tvalid <= 1'b0;

        // let the last results come out
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("sent %0d requests, checked %0d results, %0d mismatches",
                 requests_sent, results_checked, failures);
        $display("pushes dropped on full: %0d, requests on empty: %0d, ordered hits: %0d",
                 dropped_pushes, empty_requests, ordered_hits);
        if (failures == 0 && pending_results.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
